/* hdl/bpc_pkg.sv */
// ============================================================================
// Barometric pressure compensation: shared package
// Types for the transaction payloads, the calibration word set, the
// transfers between pipeline sections, and the register map.
// ============================================================================
`default_nettype none

package bpc_pkg;

    // Register map, word index on paddr[4:2].
    localparam logic [2:0] REG_PRESS_SENS  = 3'd0;
    localparam logic [2:0] REG_PRESS_OFF   = 3'd1;
    localparam logic [2:0] REG_SENS_TEMP   = 3'd2;
    localparam logic [2:0] REG_OFF_TEMP    = 3'd3;
    localparam logic [2:0] REG_REF_TEMP    = 3'd4;
    localparam logic [2:0] REG_TEMP_SLOPE  = 3'd5;

    localparam int ADDR_W = 5;

    // Input transaction.
    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } bpc_sample_t;

    // Result transaction.
    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic signed [31:0] pressure_pascal;
    } bpc_result_t;

    // The six factory calibration words.
    typedef struct packed {
        logic [15:0] press_sens;
        logic [15:0] press_off;
        logic [15:0] sens_temp;
        logic [15:0] off_temp;
        logic [15:0] ref_temp;
        logic [15:0] temp_slope;
    } bpc_coeff_t;

    // First-order terms handed from the front section to the correction section.
    typedef struct packed {
        logic               valid;
        logic [23:0]        d1;
        logic signed [19:0] temp;
        logic [17:0]        t2;
        logic signed [18:0] a;
        logic signed [19:0] b;
        logic               cold;
        logic               very_cold;
        logic signed [35:0] off;
        logic signed [34:0] sens;
    } bpc_front_t;

    // Corrected terms handed from the correction section to the pressure section.
    typedef struct packed {
        logic               valid;
        logic [23:0]        d1;
        logic signed [31:0] temp;
        logic signed [43:0] off;
        logic signed [44:0] sens;
    } bpc_corr_t;

endpackage

`default_nettype wire

/* hdl/bpc_cfg_regs.sv */
// ============================================================================
// Calibration register file
// APB-style write and read access to the six 16-bit calibration words.
// ============================================================================
`default_nettype none

module bpc_cfg_regs
    import bpc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    output bpc_coeff_t               coeff
);

    bpc_coeff_t coeff_reg;
    bpc_coeff_t coeff_next;
    logic       wr_en;
    logic [2:0] index;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign index  = paddr[4:2];
    assign coeff  = coeff_reg;

    // Write decode; writes past the last register are dropped.
    always_comb
    begin
        coeff_next = coeff_reg;
        if (wr_en)
        begin
            case (index)
                REG_PRESS_SENS: coeff_next.press_sens = pwdata[15:0];
                REG_PRESS_OFF:  coeff_next.press_off  = pwdata[15:0];
                REG_SENS_TEMP:  coeff_next.sens_temp  = pwdata[15:0];
                REG_OFF_TEMP:   coeff_next.off_temp   = pwdata[15:0];
                REG_REF_TEMP:   coeff_next.ref_temp   = pwdata[15:0];
                REG_TEMP_SLOPE: coeff_next.temp_slope = pwdata[15:0];
                default:        coeff_next = coeff_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else
        begin
            coeff_reg <= coeff_next;
        end
    end

    // Read mux.
    always_comb
    begin
        case (index)
            REG_PRESS_SENS: prdata = {16'h0, coeff_reg.press_sens};
            REG_PRESS_OFF:  prdata = {16'h0, coeff_reg.press_off};
            REG_SENS_TEMP:  prdata = {16'h0, coeff_reg.sens_temp};
            REG_OFF_TEMP:   prdata = {16'h0, coeff_reg.off_temp};
            REG_REF_TEMP:   prdata = {16'h0, coeff_reg.ref_temp};
            REG_TEMP_SLOPE: prdata = {16'h0, coeff_reg.temp_slope};
            default:        prdata = 32'h0;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/bpc_front.sv */
// ============================================================================
// Front section: temperature difference and first-order terms
// Three stages: difference, four products, then first-order temperature,
// offset and sensitivity with the flags for the low-temperature corrections.
// ============================================================================
`default_nettype none

module bpc_front
    import bpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire bpc_sample_t sample,
    input  wire bpc_coeff_t  coeff,
    output bpc_front_t       front
);

    localparam logic signed [19:0] TEMP_REF   = 20'sd2000;
    localparam logic signed [19:0] COLD_SHIFT = 20'sd3500;
    localparam logic signed [18:0] A_VCOLD    = -19'sd3500;

    // Stage 1 registers.
    logic               v1_reg;
    logic [23:0]        d1_1_reg;
    logic signed [24:0] dt_reg;
    logic signed [24:0] dt_next;

    // Stage 2 registers.
    logic               v2_reg;
    logic [23:0]        d1_2_reg;
    logic signed [41:0] p_tc_reg;
    logic signed [41:0] p_off_reg;
    logic signed [41:0] p_sens_reg;
    logic [48:0]        p_dd_reg;
    logic signed [41:0] p_tc_next;
    logic signed [41:0] p_off_next;
    logic signed [41:0] p_sens_next;
    logic signed [49:0] p_dd_next;
    logic signed [16:0] c6_s;
    logic signed [16:0] c4_s;
    logic signed [16:0] c3_s;

    // Stage 3 registers.
    bpc_front_t         front_reg;
    bpc_front_t         front_next;
    logic signed [18:0] a_w;

    // Stage 1: raw temperature minus the scaled reference.
    assign dt_next = signed'({1'b0, sample.raw_temperature})
                   - signed'({1'b0, coeff.ref_temp, 8'h00});

    // Stage 2: the temperature products.
    assign c6_s        = {1'b0, coeff.temp_slope};
    assign c4_s        = {1'b0, coeff.off_temp};
    assign c3_s        = {1'b0, coeff.sens_temp};
    assign p_tc_next   = dt_reg * c6_s;
    assign p_off_next  = dt_reg * c4_s;
    assign p_sens_next = dt_reg * c3_s;
    assign p_dd_next   = dt_reg * dt_reg;

    // Stage 3: first-order terms and range flags.
    assign a_w = p_tc_reg[41:23];

    always_comb
    begin
        front_next.valid     = v2_reg;
        front_next.d1        = d1_2_reg;
        front_next.a         = a_w;
        front_next.temp      = 20'(a_w) + TEMP_REF;
        front_next.b         = 20'(a_w) + COLD_SHIFT;
        front_next.t2        = p_dd_reg[48:31];
        front_next.cold      = a_w[18];
        front_next.very_cold = (a_w < A_VCOLD);
        front_next.off       = {4'h0, coeff.press_off, 16'h0000}
                             + {p_off_reg[41], p_off_reg[41:7]};
        front_next.sens      = {4'h0, coeff.press_sens, 15'h0000}
                             + {p_sens_reg[41], p_sens_reg[41:8]};
    end

    // Valid bits and the stage 3 register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            front_reg <= '0;
        end
        else
        begin
            v1_reg    <= start;
            v2_reg    <= v1_reg;
            front_reg <= front_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        d1_1_reg   <= sample.raw_pressure;
        dt_reg     <= dt_next;
        d1_2_reg   <= d1_1_reg;
        p_tc_reg   <= p_tc_next;
        p_off_reg  <= p_off_next;
        p_sens_reg <= p_sens_next;
        p_dd_reg   <= p_dd_next[48:0];
    end

    assign front = front_reg;

endmodule

`default_nettype wire

/* hdl/bpc_corr.sv */
// ============================================================================
// Correction section: second-order temperature, offset and sensitivity
// Two stages: squares of the temperature distances, then the correction
// sums subtracted from the first-order terms.
// ============================================================================
`default_nettype none

module bpc_corr
    import bpc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire bpc_front_t front,
    output bpc_corr_t       corr
);

    // Stage 4 registers.
    logic               v4_reg;
    logic [23:0]        d1_reg;
    logic signed [20:0] temp_reg;
    logic signed [20:0] temp_next;
    logic [36:0]        a2_reg;
    logic [37:0]        b2_reg;
    logic signed [37:0] a2_full;
    logic signed [39:0] b2_full;
    logic               cold_reg;
    logic               very_cold_reg;
    logic signed [35:0] off_reg;
    logic signed [34:0] sens_reg;

    // Stage 5 terms.
    logic [39:0]        five_a2;
    logic [40:0]        seven_b2;
    logic [41:0]        eleven_b2;
    logic [42:0]        off2;
    logic [42:0]        sens2;
    bpc_corr_t          corr_reg;
    bpc_corr_t          corr_next;

    // Stage 4: squares and the corrected temperature.
    assign a2_full   = front.a * front.a;
    assign b2_full   = front.b * front.b;
    assign temp_next = {front.temp[19], front.temp}
                     - (front.cold ? {3'b000, front.t2} : 21'd0);

    // Stage 5: offset and sensitivity corrections; each halving truncates on its own.
    assign five_a2   = {a2_reg, 2'b00} + {3'b000, a2_reg};
    assign seven_b2  = {b2_reg, 3'b000} - {3'b000, b2_reg};
    assign eleven_b2 = {1'b0, b2_reg, 3'b000} + {3'b000, b2_reg, 1'b0} + {4'h0, b2_reg};

    always_comb
    begin
        off2  = '0;
        sens2 = '0;
        if (cold_reg)
        begin
            off2  = {4'h0, five_a2[39:1]};
            sens2 = {5'h00, five_a2[39:2]};
            if (very_cold_reg)
            begin
                off2  = off2 + {2'b00, seven_b2};
                sens2 = sens2 + {2'b00, eleven_b2[41:1]};
            end
        end
        corr_next.valid = v4_reg;
        corr_next.d1    = d1_reg;
        corr_next.temp  = 32'(temp_reg);
        corr_next.off   = {{8{off_reg[35]}}, off_reg} - {1'b0, off2};
        corr_next.sens  = {{10{sens_reg[34]}}, sens_reg} - {2'b00, sens2};
    end

    // Valid bit and the stage 5 register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg   <= 1'b0;
            corr_reg <= '0;
        end
        else
        begin
            v4_reg   <= front.valid;
            corr_reg <= corr_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        d1_reg        <= front.d1;
        temp_reg      <= temp_next;
        a2_reg        <= a2_full[36:0];
        b2_reg        <= b2_full[37:0];
        cold_reg      <= front.cold;
        very_cold_reg <= front.very_cold;
        off_reg       <= front.off;
        sens_reg      <= front.sens;
    end

    assign corr = corr_reg;

endmodule

`default_nettype wire

/* hdl/bpc_press.sv */
// ============================================================================
// Pressure section: raw pressure times sensitivity, offset and scaling
// Three stages: two partial products, their sum, then the offset
// subtraction and final scaling into the result register.
// ============================================================================
`default_nettype none

module bpc_press
    import bpc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire bpc_corr_t corr,
    output logic           done,
    output bpc_result_t    result
);

    // Stage 6 registers.
    logic               v6_reg;
    logic [46:0]        pp_lo_reg;
    logic signed [46:0] pp_hi_reg;
    logic signed [46:0] pp_hi_next;
    logic signed [24:0] d1_s;
    logic signed [21:0] sens_hi;
    logic signed [31:0] temp6_reg;
    logic signed [43:0] off6_reg;

    // Stage 7 registers.
    logic               v7_reg;
    logic signed [69:0] prod_reg;
    logic signed [69:0] prod_next;
    logic signed [31:0] temp7_reg;
    logic signed [43:0] off7_reg;

    // Stage 8: result register.
    logic               done_reg;
    bpc_result_t        result_reg;
    bpc_result_t        result_next;
    logic signed [48:0] x_w;

    // Stage 6: sensitivity split into an unsigned low part and a signed high part.
    assign d1_s       = {1'b0, corr.d1};
    assign sens_hi    = corr.sens[44:23];
    assign pp_hi_next = d1_s * sens_hi;

    // Stage 7: recombine the partial products.
    assign prod_next = {pp_hi_reg, 23'h0} + {23'h0, pp_lo_reg};

    // Stage 8: scale, subtract offset, scale again, keep the low word.
    assign x_w = prod_reg[69:21] - {{5{off7_reg[43]}}, off7_reg};

    always_comb
    begin
        result_next.temperature_centi = temp7_reg;
        result_next.pressure_pascal   = x_w[46:15];
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v6_reg   <= corr.valid;
            v7_reg   <= v6_reg;
            done_reg <= v7_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pp_lo_reg  <= corr.d1 * corr.sens[22:0];
        pp_hi_reg  <= pp_hi_next;
        temp6_reg  <= corr.temp;
        off6_reg   <= corr.off;
        prod_reg   <= prod_next;
        temp7_reg  <= temp6_reg;
        off7_reg   <= off6_reg;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* hdl/barometric_pressure_compensation_unit.sv */
// ============================================================================
// Barometric pressure compensation unit
// Second-order compensation of raw pressure and temperature conversions
// with six calibration words, giving centidegrees and pascals.
// ============================================================================
//
//   Channel   Signals                               Direction  Transaction
//   -------   -----------------------------------   ---------  ---------------------------
//   sample    start, busy, sample                   in         start high while busy low
//   result    done, result                          out        one cycle with done high
//   config    psel, penable, pwrite, paddr,         in/out     APB access, pready always 1
//             pwdata, prdata, pready
//
// Each accepted transaction reaches result after passing every stage register,
// and done is high in the cycle in which it is presented. The
// eight-stage pipeline takes a new sample every cycle, so busy stays low.
// The depth is set by the chain of products: temperature products, squares,
// then the 24-by-45-bit pressure product done as two partial products and a sum.
// Reset clears the calibration words and every valid bit at once.
//
`default_nettype none

module barometric_pressure_compensation_unit
    import bpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bpc_sample_t       sample,
    output logic                   done,
    output bpc_result_t            result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    bpc_coeff_t coeff;
    bpc_front_t front;
    bpc_corr_t  corr;

    // The pipeline never stalls.
    assign busy = 1'b0;

    // Calibration registers.
    bpc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coeff   (coeff)
    );

    // First-order terms.
    bpc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start & ~busy),
        .sample (sample),
        .coeff  (coeff),
        .front  (front)
    );

    // Second-order corrections.
    bpc_corr u_corr (
        .clk   (clk),
        .rst_n (rst_n),
        .front (front),
        .corr  (corr)
    );

    // Pressure product and output register.
    bpc_press u_press (
        .clk    (clk),
        .rst_n  (rst_n),
        .corr   (corr),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire

/* bench/barometric_pressure_compensation_unit_tb.sv */
// ----------------------------------------------------------------------------
// Barometric pressure compensation unit: self-checking testbench
// Drives raw pressure and temperature conversions under several sets of
// calibration words and checks every result against a bit-exact predictor.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpc_pkg::*;

    // Word indexes past the end of the register map; writes there are dropped.
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int SETTLE_CYCLES  = 12;
    localparam int STALL_LIMIT    = 4000;
    localparam int RANDOM_PHASES  = 6;
    localparam int ITEMS_PER_PHASE = 150;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    bpc_sample_t       sample  = '0;
    logic              done;
    bpc_result_t       result;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Samples waiting to be sent, and results predicted for accepted samples.
    bpc_sample_t pending_samples[$];
    bpc_result_t expected_results[$];

    // Calibration words as the block should currently hold them.
    bpc_coeff_t cal = '0;

    int idle_pct      = 0;
    int mismatches    = 0;
    int samples_sent  = 0;
    int results_seen  = 0;
    int warm_count    = 0;
    int cold_count    = 0;
    int frigid_count  = 0;
    int cal_sets      = 0;
    int stall_cycles  = 0;

    bpc_result_t want;

    barometric_pressure_compensation_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .sample  (sample),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Second-order compensation of one sample with the given calibration words.
    function automatic bpc_result_t compensate(bpc_sample_t s, bpc_coeff_t c);
        longint d1, d2, dt, temp, off, sens, t2, off2, sens2, a, b, p;
        bpc_result_t r;
        d1    = longint'(s.raw_pressure);
        d2    = longint'(s.raw_temperature);
        dt    = d2 - longint'(c.ref_temp) * 256;
        temp  = 2000 + ((dt * longint'(c.temp_slope)) >>> 23);
        off   = longint'(c.press_off) * 65536 + ((longint'(c.off_temp) * dt) >>> 7);
        sens  = longint'(c.press_sens) * 32768 + ((longint'(c.sens_temp) * dt) >>> 8);
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        // Correction terms only exist below 20.00 C; an extra term below -15.00 C.
        if (temp < 2000)
        begin
            a     = temp - 2000;
            t2    = (dt * dt) >>> 31;
            off2  = 5 * a * a / 2;
            sens2 = 5 * a * a / 4;
            if (temp < -1500)
            begin
                b     = temp + 1500;
                off2  = off2 + 7 * b * b;
                sens2 = sens2 + 11 * b * b / 2;
                frigid_count++;
            end
            else
            begin
                cold_count++;
            end
        end
        else
        begin
            warm_count++;
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
        p    = (((d1 * sens) >>> 21) - off) >>> 15;
        r.temperature_centi = 32'(temp);
        r.pressure_pascal   = 32'(p);
        return r;
    endfunction

    // Sample driver: records each accepted transaction and offers the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start  <= 1'b0;
            sample <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.push_back(compensate(sample, cal));
                samples_sent++;
            end
            if (!start || !busy)
            begin
                if (pending_samples.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    start  <= 1'b1;
                    sample <= pending_samples.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: each strobe is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result T=%0d P=%0d with nothing expected",
                                 result.temperature_centi, result.pressure_pascal));
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.temperature_centi !== want.temperature_centi)
                    report($sformatf("temperature_centi got %0d expected %0d",
                                     result.temperature_centi, want.temperature_centi));
                if (result.pressure_pascal !== want.pressure_pascal)
                    report($sformatf("pressure_pascal got %0d expected %0d",
                                     result.pressure_pascal, want.pressure_pascal));
            end
        end
    end

    // Watchdog on cycles with neither an accepted transaction nor a result.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", stall_cycles);
            $display("barometric_pressure_compensation_unit verification failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Wait until every queued sample is sent and every result is back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || start || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        // The register takes the value at this edge.
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PRESS_SENS: cal.press_sens = value[15:0];
            REG_PRESS_OFF:  cal.press_off  = value[15:0];
            REG_SENS_TEMP:  cal.sens_temp  = value[15:0];
            REG_OFF_TEMP:   cal.off_temp   = value[15:0];
            REG_REF_TEMP:   cal.ref_temp   = value[15:0];
            REG_TEMP_SLOPE: cal.temp_slope = value[15:0];
            default: ;
        endcase
    endtask

    task automatic check_reg(input logic [2:0] idx, input logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[15:0] !== value)
            report($sformatf("register %0d reads 0x%04h expected 0x%04h",
                             idx, prdata[15:0], value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Load a full calibration set, poke the unmapped words, then read back.
    task automatic load_cal(input bpc_coeff_t c);
        write_reg(REG_PRESS_SENS, {16'($urandom_range(0, 65535)), c.press_sens});
        write_reg(REG_PRESS_OFF,  {16'($urandom_range(0, 65535)), c.press_off});
        write_reg(REG_SENS_TEMP,  {16'($urandom_range(0, 65535)), c.sens_temp});
        write_reg(REG_OFF_TEMP,   {16'($urandom_range(0, 65535)), c.off_temp});
        write_reg(REG_REF_TEMP,   {16'($urandom_range(0, 65535)), c.ref_temp});
        write_reg(REG_TEMP_SLOPE, {16'($urandom_range(0, 65535)), c.temp_slope});
        write_reg(REG_SPARE_LO, $urandom());
        write_reg(REG_SPARE_HI, $urandom());
        check_reg(REG_PRESS_SENS, cal.press_sens);
        check_reg(REG_PRESS_OFF,  cal.press_off);
        check_reg(REG_SENS_TEMP,  cal.sens_temp);
        check_reg(REG_OFF_TEMP,   cal.off_temp);
        check_reg(REG_REF_TEMP,   cal.ref_temp);
        check_reg(REG_TEMP_SLOPE, cal.temp_slope);
        cal_sets++;
    endtask

    task automatic queue_sample(input logic [23:0] pressure, input longint temperature);
        bpc_sample_t s;
        if (temperature < 0)
            temperature = 0;
        else if (temperature > 24'hFFFFFF)
            temperature = 24'hFFFFFF;
        s.raw_pressure    = pressure;
        s.raw_temperature = 24'(temperature);
        pending_samples.push_back(s);
    endtask

    // Half the readings lie around the reference temperature, the rest
    // anywhere in range or, for one in ten, pinned to the field limits.
    task automatic queue_random_sample();
        int     mode;
        longint centre;
        mode   = $urandom_range(0, 99);
        centre = longint'(cal.ref_temp) * 256;
        if (mode < 40)
            queue_sample(24'($urandom()), longint'($urandom_range(0, 24'hFFFFFF)));
        else if (mode < 70)
            queue_sample(24'($urandom()),
                         centre + longint'($urandom_range(0, 1 << 22)) - (1 << 21));
        else if (mode < 90)
            queue_sample(24'($urandom()), centre + longint'($urandom_range(0, 1024)) - 512);
        else
            queue_sample($urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000,
                         $urandom_range(0, 1) ? longint'(24'hFFFFFF) : 64'sd0);
    endtask

    function automatic bpc_coeff_t random_cal();
        bpc_coeff_t c;
        c.press_sens = 16'($urandom());
        c.press_off  = 16'($urandom());
        c.sens_temp  = 16'($urandom());
        c.off_temp   = 16'($urandom());
        c.ref_temp   = 16'($urandom());
        c.temp_slope = 16'($urandom());
        return c;
    endfunction

    initial
    begin
        bpc_coeff_t c;
        longint     mid;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Calibration words at their reset value of zero.
        idle_pct = 24;
        queue_sample(24'h000000, 0);
        queue_sample(24'hFFFFFF, 24'hFFFFFF);
        queue_sample(24'hFFFFFF, 0);
        queue_sample(24'h000000, 24'hFFFFFF);
        wait_drained();

        // A slope of 2^15 makes TEMP = 2000 + floor(dT / 256), which places
        // the warm, cold and very cold boundaries at exact raw values.
        c = '{press_sens: 16'd40127, press_off: 16'd36924, sens_temp: 16'd23317,
              off_temp: 16'd23282, ref_temp: 16'd32768, temp_slope: 16'd32768};
        load_cal(c);
        mid = longint'(c.ref_temp) * 256;
        queue_sample(24'd9085466, mid);             // exactly 20.00 C
        queue_sample(24'd9085466, mid + 255);       // still 20.00 C
        queue_sample(24'd9085466, mid - 1);         // first cold step
        queue_sample(24'd9085466, mid - 896000);    // exactly -15.00 C
        queue_sample(24'd9085466, mid - 896001);    // first very cold step
        queue_sample(24'd9085466, mid - 1000000);
        queue_sample(24'hFFFFFF, 0);
        queue_sample(24'h000000, 0);
        queue_sample(24'hFFFFFF, 24'hFFFFFF);
        queue_sample(24'h000000, 24'hFFFFFF);
        wait_drained();

        // Every calibration bit set.
        load_cal('1);
        queue_sample(24'hFFFFFF, 24'hFFFFFF);
        queue_sample(24'hFFFFFF, 0);
        queue_sample(24'h000000, 0);
        queue_sample(24'h000000, 24'hFFFFFF);
        wait_drained();

        // Random phases under varied calibration and sender idling.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: c = '{press_sens: 16'd40127, press_off: 16'd36924,
                         sens_temp: 16'd23317, off_temp: 16'd23282,
                         ref_temp: 16'd33464, temp_slope: 16'd28312};
                1: c = '1;
                3: begin
                       c = random_cal();
                       c.press_sens = '0;
                       c.press_off  = '0;
                       c.sens_temp  = '0;
                       c.off_temp   = '0;
                       c.temp_slope = '1;
                   end
                default: c = random_cal();
            endcase
            idle_pct = (phase < 2) ? 24 : (phase < 4) ? 47 : 0;
            load_cal(c);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                queue_random_sample();
            wait_drained();
        end

        $display("%0d samples sent and %0d results checked under %0d calibration sets",
                 samples_sent, results_seen, cal_sets);
        $display("%0d warm, %0d cold and %0d very cold readings, %0d mismatches",
                 warm_count, cold_count, frigid_count, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("barometric_pressure_compensation_unit verification clean");
        else
            $display("barometric_pressure_compensation_unit verification failed");
        $finish;
    end

endmodule
